// ===== design/lkv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int CAP_W        = 5;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [CAP_W-1:0]   CAPACITY_RESET = 5'd16;
  localparam logic [PADDR_W-3:0] REG_CAPACITY   = 1'b0;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE
  } lkv_state_t;

  typedef struct packed {
    logic meta_rd;
    logic meta_wr;
    logic val_rd;
    logic val_wr;
  } mem_ctl_t;

endpackage

// ===== design/lru_key_value_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel   ports                                       handshake
//   input     in_kind, in_lookup_key, in_write_value      start high, busy low
//   result    out_hit, out_read_value, out_evicted        out_valid, one cycle
//   config    psel, penable, pwrite, paddr, pwdata,       APB, pready high
//             prdata, pready
//
// A get that misses ends with the decide step after the scan pass; every other
// item also takes an update pass. Both passes run over the entry memory,
// one entry a cycle.
// busy is high from the cycle after start until the cycle of out_valid, in
// which the next word may already start. The receiver cannot stall results.
// Reset is synchronous; it clears the valid bits and the fill count at once.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF,
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_kind,
  input  logic [KEY_BITS-1:0]                in_lookup_key,
  input  logic signed [lkv_pkg::DATA_W-1:0]  in_write_value,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic signed [lkv_pkg::DATA_W-1:0]  out_read_value,
  output logic                               out_evicted,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lkv_pkg::PADDR_W-1:0]        paddr,
  input  logic [lkv_pkg::PDATA_W-1:0]        pwdata,
  output logic [lkv_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import lkv_pkg::*;

  logic [CAP_W-1:0]    capacity_r, capacity_nxt;
  logic                cfg_wr;
  logic                cfg_sel_cap;
  mem_ctl_t            mem_ctl;
  logic [IDX_W-1:0]    meta_raddr;
  logic [IDX_W-1:0]    meta_waddr;
  logic [KEY_BITS-1:0] meta_wkey;
  logic [IDX_W-1:0]    meta_wrank;
  logic [KEY_BITS-1:0] meta_rkey;
  logic [IDX_W-1:0]    meta_rrank;
  logic [IDX_W-1:0]    val_addr;
  logic [DATA_W-1:0]   val_wdata;
  logic [DATA_W-1:0]   val_rdata;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_sel_cap = (paddr[PADDR_W-1:2] == REG_CAPACITY);

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_wr && cfg_sel_cap) begin
      capacity_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  assign prdata = cfg_sel_cap ? PDATA_W'(capacity_r) : '0;

  lkv_ctrl #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .capacity       (capacity_r),
    .start          (start),
    .busy           (busy),
    .kind           (in_kind),
    .lookup_key     (in_lookup_key),
    .write_value    (in_write_value),
    .mem_ctl        (mem_ctl),
    .meta_raddr     (meta_raddr),
    .meta_waddr     (meta_waddr),
    .meta_wkey      (meta_wkey),
    .meta_wrank     (meta_wrank),
    .meta_rkey      (meta_rkey),
    .meta_rrank     (meta_rrank),
    .val_addr       (val_addr),
    .val_wdata      (val_wdata),
    .val_rdata      (val_rdata),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

  lkv_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk        (clk),
    .mem_ctl    (mem_ctl),
    .meta_raddr (meta_raddr),
    .meta_waddr (meta_waddr),
    .meta_wkey  (meta_wkey),
    .meta_wrank (meta_wrank),
    .meta_rkey  (meta_rkey),
    .meta_rrank (meta_rrank),
    .val_addr   (val_addr),
    .val_wdata  (val_wdata),
    .val_rdata  (val_rdata)
  );

endmodule

// ===== design/lkv_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_store
// Entry memories: key and recency rank per entry, and the stored values.
// Both have one write port and one registered read port.
// ----------------------------------------------------------------------------
module lkv_store #(
  parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF,
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                        clk,
  input  lkv_pkg::mem_ctl_t           mem_ctl,
  input  logic [IDX_W-1:0]            meta_raddr,
  input  logic [IDX_W-1:0]            meta_waddr,
  input  logic [KEY_BITS-1:0]         meta_wkey,
  input  logic [IDX_W-1:0]            meta_wrank,
  output logic [KEY_BITS-1:0]         meta_rkey,
  output logic [IDX_W-1:0]            meta_rrank,
  input  logic [IDX_W-1:0]            val_addr,
  input  logic [lkv_pkg::DATA_W-1:0]  val_wdata,
  output logic [lkv_pkg::DATA_W-1:0]  val_rdata
);
  import lkv_pkg::*;

  logic [KEY_BITS+IDX_W-1:0] meta_mem [ENTRIES];
  logic [DATA_W-1:0]         val_mem  [ENTRIES];
  logic [KEY_BITS+IDX_W-1:0] meta_rdata_r;
  logic [DATA_W-1:0]         val_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.meta_wr) begin
      meta_mem[meta_waddr] <= {meta_wkey, meta_wrank};
    end
    if (mem_ctl.meta_rd) begin
      meta_rdata_r <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.val_wr) begin
      val_mem[val_addr] <= val_wdata;
    end
    if (mem_ctl.val_rd) begin
      val_rdata_r <= val_mem[val_addr];
    end
  end

  assign meta_rkey  = meta_rdata_r[KEY_BITS+IDX_W-1:IDX_W];
  assign meta_rrank = meta_rdata_r[IDX_W-1:0];
  assign val_rdata  = val_rdata_r;

endmodule

// ===== design/lkv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer of the cache: a scan pass over the entry memory finds the key,
// the least recent entry and the first free slot, a decide step picks the
// action, and an update pass rewrites every rank and the target key.
// ----------------------------------------------------------------------------
module lkv_ctrl #(
  parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF,
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [lkv_pkg::CAP_W-1:0]          capacity,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic [KEY_BITS-1:0]                lookup_key,
  input  logic signed [lkv_pkg::DATA_W-1:0]  write_value,
  output lkv_pkg::mem_ctl_t                  mem_ctl,
  output logic [IDX_W-1:0]                   meta_raddr,
  output logic [IDX_W-1:0]                   meta_waddr,
  output logic [KEY_BITS-1:0]                meta_wkey,
  output logic [IDX_W-1:0]                   meta_wrank,
  input  logic [KEY_BITS-1:0]                meta_rkey,
  input  logic [IDX_W-1:0]                   meta_rrank,
  output logic [IDX_W-1:0]                   val_addr,
  output logic [lkv_pkg::DATA_W-1:0]         val_wdata,
  input  logic [lkv_pkg::DATA_W-1:0]         val_rdata,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic signed [lkv_pkg::DATA_W-1:0]  out_read_value,
  output logic                               out_evicted
);
  import lkv_pkg::*;

  localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  lkv_state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               found_r, found_nxt;
  logic               vic_any_r, vic_any_nxt;
  logic               free_any_r, free_any_nxt;
  logic               set_valid_r, set_valid_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic                kind_r, kind_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [DATA_W-1:0]   wval_r, wval_nxt;
  logic [IDX_W-1:0]    fslot_r, fslot_nxt;
  logic [IDX_W-1:0]    frank_r, frank_nxt;
  logic [IDX_W-1:0]    vslot_r, vslot_nxt;
  logic [IDX_W-1:0]    vrank_r, vrank_nxt;
  logic [IDX_W-1:0]    free_slot_r, free_slot_nxt;
  logic [IDX_W-1:0]    tgt_r, tgt_nxt;
  logic [IDX_W-1:0]    rthr_r, rthr_nxt;
  logic                age_all_r, age_all_nxt;
  logic                wkey_r, wkey_nxt;
  logic                evict_r, evict_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic                out_evicted_r, out_evicted_nxt;
  logic [DATA_W-1:0]   out_read_value_r, out_read_value_nxt;

  logic             issuing;
  logic             last;
  logic             cur_valid;
  logic             cur_match;
  logic             is_tgt;
  logic [CW-1:0]    cap_ext;
  logic [CW-1:0]    cap_eff;
  logic             fill_ok;
  logic             dec_fill;
  logic             dec_evict;
  logic             dec_upd;
  logic [IDX_W-1:0] dec_slot;

  assign last      = (cnt_r == CNT_W'(ENTRIES));
  assign issuing   = !last;
  assign cur_valid = valid_r[pend_idx_r];
  assign cur_match = cur_valid && (meta_rkey == key_r);
  assign is_tgt    = (pend_idx_r == tgt_r);

  assign cap_ext = CW'(capacity);
  assign cap_eff = (cap_ext == '0) ? CW'(1) :
                   ((cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext);
  assign fill_ok = (CW'(fill_r) < cap_eff);

  assign dec_fill  = (kind_r == KIND_PUT) && !found_r && fill_ok && free_any_r;
  assign dec_evict = (kind_r == KIND_PUT) && !found_r && !dec_fill && vic_any_r;
  assign dec_upd   = found_r || dec_fill || dec_evict;
  assign dec_slot  = found_r ? fslot_r : (dec_fill ? free_slot_r : vslot_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = dec_upd ? ST_UPDATE : ST_IDLE;
      end
      ST_UPDATE: begin
        if (last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt            = cnt_r;
    pend_nxt           = 1'b0;
    pend_idx_nxt       = cnt_r[IDX_W-1:0];
    valid_nxt          = valid_r;
    fill_nxt           = fill_r;
    found_nxt          = found_r;
    vic_any_nxt        = vic_any_r;
    free_any_nxt       = free_any_r;
    set_valid_nxt      = set_valid_r;
    out_valid_nxt      = 1'b0;
    kind_nxt           = kind_r;
    key_nxt            = key_r;
    wval_nxt           = wval_r;
    fslot_nxt          = fslot_r;
    frank_nxt          = frank_r;
    vslot_nxt          = vslot_r;
    vrank_nxt          = vrank_r;
    free_slot_nxt      = free_slot_r;
    tgt_nxt            = tgt_r;
    rthr_nxt           = rthr_r;
    age_all_nxt        = age_all_r;
    wkey_nxt           = wkey_r;
    evict_nxt          = evict_r;
    out_hit_nxt        = out_hit_r;
    out_evicted_nxt    = out_evicted_r;
    out_read_value_nxt = out_read_value_r;
    mem_ctl            = '0;
    meta_raddr         = cnt_r[IDX_W-1:0];
    meta_waddr         = pend_idx_r;
    meta_wkey          = (is_tgt && wkey_r) ? key_r : meta_rkey;
    meta_wrank         = meta_rrank;
    val_addr           = dec_slot;
    val_wdata          = wval_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt      = '0;
          found_nxt    = 1'b0;
          vic_any_nxt  = 1'b0;
          free_any_nxt = 1'b0;
          kind_nxt     = kind;
          key_nxt      = lookup_key;
          wval_nxt     = write_value;
        end
      end
      ST_SCAN: begin
        mem_ctl.meta_rd = issuing;
        pend_nxt        = issuing;
        if (issuing) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (pend_r) begin
          if (cur_match) begin
            found_nxt = 1'b1;
            fslot_nxt = pend_idx_r;
            frank_nxt = meta_rrank;
          end
          if (cur_valid && (!vic_any_r || (meta_rrank > vrank_r))) begin
            vic_any_nxt = 1'b1;
            vslot_nxt   = pend_idx_r;
            vrank_nxt   = meta_rrank;
          end
          if (!cur_valid && !free_any_r) begin
            free_any_nxt  = 1'b1;
            free_slot_nxt = pend_idx_r;
          end
        end
      end
      ST_DECIDE: begin
        cnt_nxt        = '0;
        mem_ctl.val_rd = found_r && (kind_r == KIND_GET);
        mem_ctl.val_wr = (kind_r == KIND_PUT) && dec_upd;
        tgt_nxt        = dec_slot;
        rthr_nxt       = found_r ? frank_r : vrank_r;
        age_all_nxt    = dec_fill;
        wkey_nxt       = dec_fill || dec_evict;
        set_valid_nxt  = dec_fill;
        evict_nxt      = dec_evict;
        if (!dec_upd) begin
          out_valid_nxt      = 1'b1;
          out_hit_nxt        = 1'b0;
          out_evicted_nxt    = 1'b0;
          out_read_value_nxt = '0;
        end
      end
      ST_UPDATE: begin
        mem_ctl.meta_rd = issuing;
        pend_nxt        = issuing;
        if (issuing) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        mem_ctl.meta_wr = pend_r;
        if (is_tgt) begin
          meta_wrank = '0;
        end else if (cur_valid && (age_all_r || (meta_rrank < rthr_r))) begin
          meta_wrank = meta_rrank + IDX_W'(1);
        end
        if (last) begin
          if (set_valid_r) begin
            valid_nxt[tgt_r] = 1'b1;
            fill_nxt         = fill_r + CNT_W'(1);
          end
          out_valid_nxt      = 1'b1;
          out_hit_nxt        = found_r;
          out_evicted_nxt    = evict_r;
          out_read_value_nxt = (found_r && (kind_r == KIND_GET)) ? val_rdata : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      fill_r      <= '0;
      found_r     <= 1'b0;
      vic_any_r   <= 1'b0;
      free_any_r  <= 1'b0;
      set_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      fill_r      <= fill_nxt;
      found_r     <= found_nxt;
      vic_any_r   <= vic_any_nxt;
      free_any_r  <= free_any_nxt;
      set_valid_r <= set_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r       <= pend_idx_nxt;
    kind_r           <= kind_nxt;
    key_r            <= key_nxt;
    wval_r           <= wval_nxt;
    fslot_r          <= fslot_nxt;
    frank_r          <= frank_nxt;
    vslot_r          <= vslot_nxt;
    vrank_r          <= vrank_nxt;
    free_slot_r      <= free_slot_nxt;
    tgt_r            <= tgt_nxt;
    rthr_r           <= rthr_nxt;
    age_all_r        <= age_all_nxt;
    wkey_r           <= wkey_nxt;
    evict_r          <= evict_nxt;
    out_hit_r        <= out_hit_nxt;
    out_evicted_r    <= out_evicted_nxt;
    out_read_value_r <= out_read_value_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_evicted    = out_evicted_r;
  assign out_read_value = out_read_value_r;

endmodule
